>>> sv/tabg_pkg.sv
`default_nettype none

package tabg_pkg;

    // Field widths
    localparam int IDX_W  = 15;   // magnitude of a non-negative tile index
    localparam int ACOL_W = 13;   // atlas column count

    // Result status codes
    localparam logic [1:0] STATUS_DRAW  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Register indexes on the config port
    localparam logic [3:0] REG_TILE_WIDTH    = 4'd0;
    localparam logic [3:0] REG_TILE_HEIGHT   = 4'd1;
    localparam logic [3:0] REG_ATLAS_MARGIN  = 4'd2;
    localparam logic [3:0] REG_ATLAS_SPACING = 4'd3;
    localparam logic [3:0] REG_ATLAS_COLUMNS = 4'd4;
    localparam logic [3:0] REG_TILE_TOTAL    = 4'd5;
    localparam logic [3:0] REG_MAP_COLUMNS   = 4'd6;
    localparam logic [3:0] REG_DRAW_SCALE    = 4'd7;

    // Divider result bundle
    typedef struct packed {
        logic              done;   // one-cycle pulse, quot/rem valid from here on
        logic [IDX_W-1:0]  quot;
        logic [ACOL_W-1:0] rem;
    } div_res_t;

endpackage

`default_nettype wire

>>> sv/tile_atlas_blit_address_gen.sv
`default_nettype none

// Channel    | Dir | Handshake          | Contents
// s_ (entry) | in  | s_tvalid/s_tready  | tile index, map origin, restart flag
// m_ (blit)  | out | m_tvalid/m_tready  | status, atlas source and screen rectangle
// cfg_       | in  | cfg_wr_en          | register index and write data
//
// Drawn entry: the divider produces 15 quotient bits, then the done handoff,
// 6 multiplier steps and the output load follow in that order.
// Empty or out-of-range entry: skips divider and multiplier, straight to the load.
// One entry in flight; the next request is taken while the last result waits.
// aresetn is synchronous: config returns to defaults, map position to 0,0.
// A stalled output holds its result; the block waits in its final state.
module tile_atlas_blit_address_gen (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // entry request
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [47:0]  s_tdata,   // tile_num, origin_x, origin_y
    input  wire logic         s_tuser,   // first_of_map
    // blit result
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [167:0] m_tdata,   // src_x, src_y, src_w, src_h, dst_left,
                                         // dst_top, dst_w, dst_h, zero pad
    output      logic [1:0]   m_tuser,   // status
    // config write
    input  wire logic         cfg_wr_en,
    input  wire logic [3:0]   cfg_index,
    input  wire logic [15:0]  cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [2:0] MUL_DW   = 3'd0;
    localparam logic [2:0] MUL_DH   = 3'd1;
    localparam logic [2:0] MUL_SX   = 3'd2;
    localparam logic [2:0] MUL_SY   = 3'd3;
    localparam logic [2:0] MUL_DL   = 3'd4;
    localparam logic [2:0] MUL_LAST = 3'd5;

    // Config registers
    logic [10:0] tile_width_reg, tile_height_reg, atlas_margin_reg, atlas_spacing_reg;
    logic [12:0] atlas_columns_reg, map_columns_reg;
    logic [15:0] tile_total_reg;
    logic [4:0]  draw_scale_reg;

    // Control
    logic [1:0]  state_reg;
    logic [2:0]  step_reg;
    logic [11:0] map_col_reg, map_row_reg;
    logic        m_tvalid_reg;

    // Captured entry
    logic [1:0]  status_reg;
    logic [15:0] ox_reg, oy_reg;
    logic [11:0] pos_col_reg, pos_row_reg;

    // Products
    logic [15:0] dw_reg, dh_reg;
    logic [23:0] px_reg, py_reg;
    logic [27:0] pl_reg, pt_reg;

    // Output payload
    logic [167:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    logic        accept;
    logic        restart;
    logic [11:0] cur_col, cur_row;
    logic [12:0] col_inc;
    logic        col_wrap;
    logic [1:0]  status_in;
    logic [tabg_pkg::ACOL_W-1:0] acols;
    logic        out_free;

    logic [14:0] mul_a;
    logic [15:0] mul_b;
    logic [30:0] mul_p;

    tabg_pkg::div_res_t div_res;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg    <= 11'd16;
            tile_height_reg   <= 11'd16;
            atlas_margin_reg  <= 11'd0;
            atlas_spacing_reg <= 11'd0;
            atlas_columns_reg <= 13'd1;
            tile_total_reg    <= 16'd1;
            map_columns_reg   <= 13'd1;
            draw_scale_reg    <= 5'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tabg_pkg::REG_TILE_WIDTH:    tile_width_reg    <= cfg_wdata[10:0];
                tabg_pkg::REG_TILE_HEIGHT:   tile_height_reg   <= cfg_wdata[10:0];
                tabg_pkg::REG_ATLAS_MARGIN:  atlas_margin_reg  <= cfg_wdata[10:0];
                tabg_pkg::REG_ATLAS_SPACING: atlas_spacing_reg <= cfg_wdata[10:0];
                tabg_pkg::REG_ATLAS_COLUMNS: atlas_columns_reg <= cfg_wdata[12:0];
                tabg_pkg::REG_TILE_TOTAL:    tile_total_reg    <= cfg_wdata;
                tabg_pkg::REG_MAP_COLUMNS:   map_columns_reg   <= cfg_wdata[12:0];
                tabg_pkg::REG_DRAW_SCALE:    draw_scale_reg    <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Map position of the incoming entry and its advance
    assign restart = s_tuser;
    assign cur_col = restart ? 12'd0 : map_col_reg;
    assign cur_row = restart ? 12'd0 : map_row_reg;
    assign col_inc = {1'b0, cur_col} + 13'd1;

    always_comb begin
        if (map_columns_reg == 13'd0) begin
            col_wrap = 1'b1;
        end else if (map_columns_reg > 13'd4096) begin
            col_wrap = col_inc[12];
        end else begin
            col_wrap = (col_inc >= map_columns_reg);
        end
    end

    // Classify the entry
    always_comb begin
        if (s_tdata[15]) begin
            status_in = tabg_pkg::STATUS_EMPTY;
        end else if ({1'b0, s_tdata[14:0]} >= tile_total_reg) begin
            status_in = tabg_pkg::STATUS_RANGE;
        end else begin
            status_in = tabg_pkg::STATUS_DRAW;
        end
    end

    assign acols = (atlas_columns_reg == 13'd0) ? 13'd1 : atlas_columns_reg;

    tabg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && (status_in == tabg_pkg::STATUS_DRAW)),
        .dividend (s_tdata[14:0]),
        .divisor  (acols),
        .res      (div_res)
    );

    // Shared multiplier operand select
    always_comb begin
        case (step_reg)
            MUL_DW: begin
                mul_a = 15'(tile_width_reg);
                mul_b = 16'(draw_scale_reg);
            end
            MUL_DH: begin
                mul_a = 15'(tile_height_reg);
                mul_b = 16'(draw_scale_reg);
            end
            MUL_SX: begin
                mul_a = 15'(div_res.rem);
                mul_b = 16'({1'b0, tile_width_reg} + {1'b0, atlas_spacing_reg});
            end
            MUL_SY: begin
                mul_a = div_res.quot;
                mul_b = 16'({1'b0, tile_height_reg} + {1'b0, atlas_spacing_reg});
            end
            MUL_DL: begin
                mul_a = 15'(pos_col_reg);
                mul_b = dw_reg;
            end
            default: begin
                mul_a = 15'(pos_row_reg);
                mul_b = dh_reg;
            end
        endcase
    end

    assign mul_p = 31'(mul_a) * 31'(mul_b);

    // Sequencer and map state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            map_col_reg  <= '0;
            map_row_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        map_col_reg <= col_wrap ? 12'd0 : col_inc[11:0];
                        map_row_reg <= col_wrap ? cur_row + 12'd1 : cur_row;
                        state_reg   <= (status_in == tabg_pkg::STATUS_DRAW) ? ST_DIV
                                                                           : ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        state_reg <= ST_MUL;
                        step_reg  <= MUL_DW;
                    end
                end
                ST_MUL: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == MUL_LAST) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Entry capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_in;
            ox_reg      <= s_tdata[31:16];
            oy_reg      <= s_tdata[47:32];
            pos_col_reg <= cur_col;
            pos_row_reg <= cur_row;
        end
    end

    // Product registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            case (step_reg)
                MUL_DW:  dw_reg <= mul_p[15:0];
                MUL_DH:  dh_reg <= mul_p[15:0];
                MUL_SX:  px_reg <= mul_p[23:0];
                MUL_SY:  py_reg <= mul_p[23:0];
                MUL_DL:  pl_reg <= mul_p[27:0];
                default: pt_reg <= mul_p[27:0];
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tuser_reg <= status_reg;
            if (status_reg == tabg_pkg::STATUS_DRAW) begin
                m_tdata_reg <= {
                    4'd0,
                    dh_reg[14:0],
                    dw_reg[14:0],
                    {{16{oy_reg[15]}}, oy_reg} + {4'd0, pt_reg},
                    {{16{ox_reg[15]}}, ox_reg} + {4'd0, pl_reg},
                    tile_height_reg,
                    tile_width_reg,
                    24'(atlas_margin_reg) + py_reg,
                    24'(atlas_margin_reg) + px_reg
                };
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_mul_only_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (status_reg == tabg_pkg::STATUS_DRAW))
        else $error("multiply phase entered for a skipped entry");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented without finishing an entry");

    a_skip_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg != tabg_pkg::STATUS_DRAW)) |-> (m_tdata_reg == '0))
        else $error("skipped entry carries nonzero rectangle data");

endmodule

`default_nettype wire

>>> sv/tabg_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tabg_divider (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [tabg_pkg::IDX_W-1:0]     dividend,
    input  wire logic [tabg_pkg::ACOL_W-1:0]    divisor,   // nonzero
    output tabg_pkg::div_res_t                  res
);

    localparam int            CNT_W    = $clog2(tabg_pkg::IDX_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tabg_pkg::IDX_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [tabg_pkg::ACOL_W-1:0]   rem_reg;
    logic [tabg_pkg::IDX_W-1:0]    quot_reg;
    logic [tabg_pkg::ACOL_W-1:0]   dvsr_reg;

    logic [tabg_pkg::ACOL_W:0]     trial;
    logic                          fits;

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quot_reg[tabg_pkg::IDX_W-1]};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= fits ? tabg_pkg::ACOL_W'(trial - {1'b0, dvsr_reg})
                             : trial[tabg_pkg::ACOL_W-1:0];
            quot_reg <= {quot_reg[tabg_pkg::IDX_W-2:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

    // Checks
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dvsr_reg))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
